[rtl/fdmo_pkg.sv]
// ----------------------------------------------------------------------------
// fdmo_pkg
// shared widths, register map, codes and payload types of the fall detector
// and motion odometer
// ----------------------------------------------------------------------------
package fdmo_pkg;

  // parameter defaults
  localparam int DISTANCE_BITS_DEF = 48;
  localparam int TIME_BITS_DEF     = 32;

  // fixed field widths
  localparam int ACCEL_W     = 16;
  localparam int STAMP_W     = 32;
  localparam int MAG_W       = 32;
  localparam int THRESH_W    = 32;
  localparam int WINDOW_W    = 16;
  localparam int TIMEOUT_W   = 32;
  localparam int SPEED_W     = 16;
  localparam int DIST_OUT_W  = 48;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // register map
  localparam logic [CFG_INDEX_W-1:0] REG_FREE_FALL_THRESHOLD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMPACT_THRESHOLD      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTION_HIGH_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTION_LOW_THRESHOLD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HIT_WINDOW_MS         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FALL_TIMEOUT_MS       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WALKING_SPEED_MM_S    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_ENABLED        = 3'd7;

  // register reset values (thresholds in counts squared, 4096 counts per g)
  localparam logic [THRESH_W-1:0]  RST_FREE_FALL_THRESHOLD   = 32'd2684355;
  localparam logic [THRESH_W-1:0]  RST_IMPACT_THRESHOLD      = 32'd104857600;
  localparam logic [THRESH_W-1:0]  RST_MOTION_HIGH_THRESHOLD = 32'd22145925;
  localparam logic [THRESH_W-1:0]  RST_MOTION_LOW_THRESHOLD  = 32'd12079596;
  localparam logic [WINDOW_W-1:0]  RST_HIT_WINDOW_MS         = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] RST_FALL_TIMEOUT_MS       = 32'd30000;
  localparam logic [SPEED_W-1:0]   RST_WALKING_SPEED_MM_S    = 16'd1250;
  localparam logic                 RST_SENSOR_ENABLED        = 1'b1;

  // item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic [THRESH_W-1:0]  free_fall_threshold;
    logic [THRESH_W-1:0]  impact_threshold;
    logic [THRESH_W-1:0]  motion_high_threshold;
    logic [THRESH_W-1:0]  motion_low_threshold;
    logic [WINDOW_W-1:0]  hit_window_ms;
    logic [TIMEOUT_W-1:0] fall_timeout_ms;
    logic [SPEED_W-1:0]   walking_speed_mm_s;
    logic                 sensor_enabled;
  } cfg_t;

  typedef struct packed {
    logic                      operation;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic [STAMP_W-1:0]        now_ms;
  } sample_t;

  typedef struct packed {
    logic                  fall_flag;
    logic                  fall_event;
    logic                  moving;
    logic [SPEED_W-1:0]    speed_mm_s;
    logic [DIST_OUT_W-1:0] distance_um;
    logic [MAG_W-1:0]      magnitude_sq;
  } result_t;

endpackage

[rtl/fdmo_sample_if.sv]
// ----------------------------------------------------------------------------
// fdmo_sample_if
// valid/ready channel carrying one sensor or clear item
// ----------------------------------------------------------------------------
interface fdmo_sample_if;
  import fdmo_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;
  logic [STAMP_W-1:0]        now_ms;

  modport source (
    output valid, operation, accel_x, accel_y, accel_z, now_ms,
    input  ready
  );

  modport sink (
    input  valid, operation, accel_x, accel_y, accel_z, now_ms,
    output ready
  );
endinterface

[rtl/fdmo_result_if.sv]
// ----------------------------------------------------------------------------
// fdmo_result_if
// valid/ready channel carrying one result item
// ----------------------------------------------------------------------------
interface fdmo_result_if;
  import fdmo_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  fall_flag;
  logic                  fall_event;
  logic                  moving;
  logic [SPEED_W-1:0]    speed_mm_s;
  logic [DIST_OUT_W-1:0] distance_um;
  logic [MAG_W-1:0]      magnitude_sq;

  modport source (
    output valid, fall_flag, fall_event, moving, speed_mm_s, distance_um,
           magnitude_sq,
    input  ready
  );

  modport sink (
    input  valid, fall_flag, fall_event, moving, speed_mm_s, distance_um,
           magnitude_sq,
    output ready
  );
endinterface

[rtl/fdmo_tracker.sv]
// ----------------------------------------------------------------------------
// fdmo_tracker
// fall and motion state with its combinational update for one item
// ----------------------------------------------------------------------------
module fdmo_tracker #(
  parameter int DISTANCE_BITS = fdmo_pkg::DISTANCE_BITS_DEF,
  parameter int TIME_BITS     = fdmo_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  fdmo_pkg::cfg_t    cfg,
  input  fdmo_pkg::sample_t item,
  output fdmo_pkg::result_t res
);
  import fdmo_pkg::*;

  localparam int MUL_W = SPEED_W + TIME_BITS;
  localparam int SUM_W = ((DISTANCE_BITS > MUL_W) ? DISTANCE_BITS : MUL_W) + 1;
  localparam logic [DISTANCE_BITS-1:0] DIST_MAX = '1;

  // state
  logic                     free_fall_armed;
  logic [TIME_BITS-1:0]     free_fall_start;
  logic                     fall_latch;
  logic [TIME_BITS-1:0]     fall_time;
  logic                     have_last_time;
  logic [TIME_BITS-1:0]     last_time;
  logic [DISTANCE_BITS-1:0] distance_total;
  logic                     moving_flag;

  logic                     free_fall_armed_next;
  logic [TIME_BITS-1:0]     free_fall_start_next;
  logic                     fall_latch_next;
  logic [TIME_BITS-1:0]     fall_time_next;
  logic                     have_last_time_next;
  logic [TIME_BITS-1:0]     last_time_next;
  logic [DISTANCE_BITS-1:0] distance_total_next;
  logic                     moving_flag_next;

  logic [TIME_BITS-1:0]     now;
  logic signed [MAG_W-1:0]  sq_x, sq_y, sq_z;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         mag_out;
  logic [TIME_BITS-1:0]     dt;
  logic [MUL_W-1:0]         walk_add;
  logic [TIME_BITS-1:0]     ff_elapsed;
  logic [TIME_BITS-1:0]     fall_elapsed;
  logic [SUM_W-1:0]         dist_sum;
  logic                     event_hit;
  logic [63:0]              dist_wide;

  assign now  = item.now_ms[TIME_BITS-1:0];

  // squarers and the speed product work side by side
  assign sq_x = $signed(item.accel_x) * $signed(item.accel_x);
  assign sq_y = $signed(item.accel_y) * $signed(item.accel_y);
  assign sq_z = $signed(item.accel_z) * $signed(item.accel_z);
  assign mag  = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

  assign dt       = have_last_time ? (now - last_time) : '0;
  assign walk_add = MUL_W'(cfg.walking_speed_mm_s) * MUL_W'(dt);
  assign dist_sum = SUM_W'(distance_total) + SUM_W'(walk_add);

  always_comb begin
    free_fall_armed_next = free_fall_armed;
    free_fall_start_next = free_fall_start;
    fall_latch_next      = fall_latch;
    fall_time_next       = fall_time;
    have_last_time_next  = have_last_time;
    last_time_next       = last_time;
    distance_total_next  = distance_total;
    moving_flag_next     = moving_flag;
    event_hit            = 1'b0;
    mag_out              = '0;
    ff_elapsed           = '0;
    fall_elapsed         = '0;

    if (item.operation == OP_CLEAR) begin
      fall_latch_next      = 1'b0;
      fall_time_next       = '0;
      free_fall_armed_next = 1'b0;
      free_fall_start_next = '0;
    end else if (cfg.sensor_enabled) begin
      mag_out = mag;

      if (mag < cfg.free_fall_threshold) begin
        free_fall_armed_next = 1'b1;
        free_fall_start_next = now;
      end

      ff_elapsed = now - free_fall_start_next;
      if (mag > cfg.impact_threshold && free_fall_armed_next &&
          32'(ff_elapsed) < 32'(cfg.hit_window_ms)) begin
        fall_latch_next      = 1'b1;
        event_hit            = 1'b1;
        fall_time_next       = now;
        free_fall_armed_next = 1'b0;
        free_fall_start_next = '0;
      end

      fall_elapsed = now - fall_time_next;
      if (fall_latch_next && 32'(fall_elapsed) > cfg.fall_timeout_ms) begin
        fall_latch_next      = 1'b0;
        fall_time_next       = '0;
        free_fall_armed_next = 1'b0;
        free_fall_start_next = '0;
      end

      have_last_time_next = 1'b1;
      last_time_next      = now;

      moving_flag_next = (mag > cfg.motion_high_threshold) ||
                         (mag < cfg.motion_low_threshold);
      if (moving_flag_next) begin
        if (dist_sum > SUM_W'(DIST_MAX)) begin
          distance_total_next = DIST_MAX;
        end else begin
          distance_total_next = dist_sum[DISTANCE_BITS-1:0];
        end
      end
    end
  end

  assign dist_wide = 64'(distance_total_next);

  always_comb begin
    res.fall_flag    = fall_latch_next;
    res.fall_event   = event_hit;
    res.moving       = moving_flag_next;
    res.speed_mm_s   = moving_flag_next ? cfg.walking_speed_mm_s : '0;
    res.distance_um  = dist_wide[DIST_OUT_W-1:0];
    res.magnitude_sq = mag_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_fall_armed <= 1'b0;
      free_fall_start <= '0;
      fall_latch      <= 1'b0;
      fall_time       <= '0;
      have_last_time  <= 1'b0;
      last_time       <= '0;
      distance_total  <= '0;
      moving_flag     <= 1'b0;
    end else if (step) begin
      free_fall_armed <= free_fall_armed_next;
      free_fall_start <= free_fall_start_next;
      fall_latch      <= fall_latch_next;
      fall_time       <= fall_time_next;
      have_last_time  <= have_last_time_next;
      last_time       <= last_time_next;
      distance_total  <= distance_total_next;
      moving_flag     <= moving_flag_next;
    end
  end

endmodule

[rtl/fall_detect_and_motion_odometer_unit.sv]
// ----------------------------------------------------------------------------
// fall_detect_and_motion_odometer_unit
// free-fall/impact fall detector with a walking-speed distance odometer
// ----------------------------------------------------------------------------
// flow: an accepted item waits in the input register until the result register
//   has room, then its result is registered there and offered downstream
// throughput: one item per cycle unless the result side stalls; the state update
//   (squarers, compares, one speed-times-time multiply-accumulate) is combinational
// reset: synchronous rst empties both stages, clears all fall and motion
//   state and loads every register with its default value
module fall_detect_and_motion_odometer_unit #(
  parameter int DISTANCE_BITS = fdmo_pkg::DISTANCE_BITS_DEF,
  parameter int TIME_BITS     = fdmo_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  fdmo_sample_if.sink                      sample,
  fdmo_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [fdmo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fdmo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fdmo_pkg::*;

  // configuration registers
  cfg_t    cfg;

  // input stage
  logic    held_valid;
  sample_t held;

  // result stage, parts the tracker from the downstream handshake
  logic    res_valid;
  result_t res_q;
  result_t res_comb;

  logic    res_free;
  logic    advance;

  // result register can take a new item when empty or being drained
  assign res_free     = !res_valid || result.ready;
  // the held item is processed and its state committed in this cycle
  assign advance      = held_valid && res_free;
  assign sample.ready = !held_valid || advance;

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.free_fall_threshold   <= RST_FREE_FALL_THRESHOLD;
      cfg.impact_threshold      <= RST_IMPACT_THRESHOLD;
      cfg.motion_high_threshold <= RST_MOTION_HIGH_THRESHOLD;
      cfg.motion_low_threshold  <= RST_MOTION_LOW_THRESHOLD;
      cfg.hit_window_ms         <= RST_HIT_WINDOW_MS;
      cfg.fall_timeout_ms       <= RST_FALL_TIMEOUT_MS;
      cfg.walking_speed_mm_s    <= RST_WALKING_SPEED_MM_S;
      cfg.sensor_enabled        <= RST_SENSOR_ENABLED;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREE_FALL_THRESHOLD:   cfg.free_fall_threshold   <= cfg_data[THRESH_W-1:0];
        REG_IMPACT_THRESHOLD:      cfg.impact_threshold      <= cfg_data[THRESH_W-1:0];
        REG_MOTION_HIGH_THRESHOLD: cfg.motion_high_threshold <= cfg_data[THRESH_W-1:0];
        REG_MOTION_LOW_THRESHOLD:  cfg.motion_low_threshold  <= cfg_data[THRESH_W-1:0];
        REG_HIT_WINDOW_MS:         cfg.hit_window_ms         <= cfg_data[WINDOW_W-1:0];
        REG_FALL_TIMEOUT_MS:       cfg.fall_timeout_ms       <= cfg_data[TIMEOUT_W-1:0];
        REG_WALKING_SPEED_MM_S:    cfg.walking_speed_mm_s    <= cfg_data[SPEED_W-1:0];
        REG_SENSOR_ENABLED:        cfg.sensor_enabled        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register: holds the item until the result stage has room
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample.ready) begin
      held_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      held.operation <= sample.operation;
      held.accel_x   <= sample.accel_x;
      held.accel_y   <= sample.accel_y;
      held.accel_z   <= sample.accel_z;
      held.now_ms    <= sample.now_ms;
    end
  end

  // fall and odometer state, updated once per processed item
  fdmo_tracker #(
    .DISTANCE_BITS (DISTANCE_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_tracker (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cfg  (cfg),
    .item (held),
    .res  (res_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign result.valid        = res_valid;
  assign result.fall_flag    = res_q.fall_flag;
  assign result.fall_event   = res_q.fall_event;
  assign result.moving       = res_q.moving;
  assign result.speed_mm_s   = res_q.speed_mm_s;
  assign result.distance_um  = res_q.distance_um;
  assign result.magnitude_sq = res_q.magnitude_sq;

  // a fresh impact always leaves the fall latched on the same item
  a_event_latches: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.fall_event) |-> result.fall_flag)
    else $error("fall event reported without latched fall");

  // no motion means no speed estimate
  a_still_no_speed: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.moving) |-> (result.speed_mm_s == '0))
    else $error("speed reported while not moving");

  // a processed item must show up in the result register
  a_advance_delivers: assert property (@(posedge clk) disable iff (rst)
    ($past(advance) && !$past(rst)) |-> res_valid)
    else $error("processed item lost before the result register");

endmodule

[dv/fall_detect_and_motion_odometer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fall_detect_and_motion_odometer_unit_tb
// self-checking bench for the fall detector and odometer: directed fall,
// timeout, wrap and saturation cases, then shaped random traffic under
// several register settings, each result checked against a local predictor
// ----------------------------------------------------------------------------
module fall_detect_and_motion_odometer_unit_tb;
  import fdmo_pkg::*;

  localparam int CLK_HALF_NS  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT     = 29;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_SHOWN    = 10;
  localparam int PHASE_ITEMS  = 250;

  // largest squared magnitude the axes can produce
  localparam logic [MAG_W-1:0] MAG_TOP   = 32'hC000_0000;
  // saturation ceiling of the distance total
  localparam logic [63:0]      DIST_CEIL = 64'h0000_FFFF_FFFF_FFFF;

  // shapes of generated samples
  typedef enum int {SHAPE_REST, SHAPE_FREE, SHAPE_HARD, SHAPE_WALK, SHAPE_ANY} shape_e;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fdmo_sample_if sample_ch ();
  fdmo_result_if result_ch ();

  fall_detect_and_motion_odometer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of registers and state
  cfg_t               cur_cfg;
  logic               ff_armed;
  logic [STAMP_W-1:0] ff_start;
  logic               fall_latched;
  logic [STAMP_W-1:0] fall_stamp;
  logic               seen_sample;
  logic [STAMP_W-1:0] prev_stamp;
  logic [63:0]        dist_acc;
  logic               moving_now;

  // reports still owed by the block, oldest first
  result_t pending_reports[$];

  int errors          = 0;
  int items_sent      = 0;
  int clears_sent     = 0;
  int reports_checked = 0;
  int falls_seen      = 0;
  int timeouts_seen   = 0;
  int sat_seen        = 0;

  // random idling on both channels while set
  bit throttle = 1'b1;

  // running timestamp of generated samples
  logic [STAMP_W-1:0] stamp_ms;

  always begin
    #(CLK_HALF_NS) clk = 1'b1;
    #(CLK_HALF_NS) clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // drop the fall latch together with any armed free fall
  function automatic void drop_fall();
    fall_latched = 1'b0;
    fall_stamp   = '0;
    ff_armed     = 1'b0;
    ff_start     = '0;
  endfunction

  // advance the predicted state by one accepted item and form its report
  function automatic result_t fall_and_distance_step(input sample_t s);
    result_t            r;
    logic [MAG_W-1:0]   mag;
    logic [STAMP_W-1:0] now;
    logic [STAMP_W-1:0] elapsed;
    logic [STAMP_W-1:0] dt;
    logic [63:0]        add;
    longint             sx, sy, sz;
    r   = '0;
    mag = '0;
    now = s.now_ms;
    if (s.operation == OP_CLEAR) begin
      drop_fall();
    end else if (cur_cfg.sensor_enabled) begin
      sx  = s.accel_x;
      sy  = s.accel_y;
      sz  = s.accel_z;
      mag = MAG_W'(sx * sx + sy * sy + sz * sz);
      // free-fall arm comes first, so one sample can arm and hit
      if (mag < cur_cfg.free_fall_threshold) begin
        ff_armed = 1'b1;
        ff_start = now;
      end
      elapsed = now - ff_start;
      if (mag > cur_cfg.impact_threshold && ff_armed &&
          elapsed < {16'd0, cur_cfg.hit_window_ms}) begin
        fall_latched = 1'b1;
        fall_stamp   = now;
        ff_armed     = 1'b0;
        ff_start     = '0;
        r.fall_event = 1'b1;
        falls_seen++;
      end
      elapsed = now - fall_stamp;
      if (fall_latched && elapsed > cur_cfg.fall_timeout_ms) begin
        drop_fall();
        timeouts_seen++;
      end
      // first sample since reset only records its time
      dt          = seen_sample ? now - prev_stamp : '0;
      seen_sample = 1'b1;
      prev_stamp  = now;
      moving_now  = (mag > cur_cfg.motion_high_threshold) ||
                    (mag < cur_cfg.motion_low_threshold);
      if (moving_now) begin
        add = 64'(cur_cfg.walking_speed_mm_s) * 64'(dt);
        if (add > DIST_CEIL - dist_acc) begin
          dist_acc = DIST_CEIL;
          sat_seen++;
        end else begin
          dist_acc = dist_acc + add;
        end
      end
    end
    r.fall_flag    = fall_latched;
    r.moving       = moving_now;
    r.speed_mm_s   = moving_now ? cur_cfg.walking_speed_mm_s : '0;
    r.distance_um  = dist_acc[DIST_OUT_W-1:0];
    r.magnitude_sq = mag;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic sample_t make_item(input logic op,
                                        input logic signed [ACCEL_W-1:0] x,
                                        input logic signed [ACCEL_W-1:0] y,
                                        input logic signed [ACCEL_W-1:0] z,
                                        input logic [STAMP_W-1:0] ms);
    sample_t s;
    s.operation = op;
    s.accel_x   = x;
    s.accel_y   = y;
    s.accel_z   = z;
    s.now_ms    = ms;
    return s;
  endfunction

  // clear item with random payload
  function automatic sample_t make_clear();
    return make_item(OP_CLEAR, ACCEL_W'($urandom), ACCEL_W'($urandom),
                     ACCEL_W'($urandom), $urandom);
  endfunction

  // value within span of centre
  function automatic logic signed [ACCEL_W-1:0] jitter(input int centre, input int span);
    return ACCEL_W'(centre - span + int'($urandom_range(2 * span)));
  endfunction

  // sample whose magnitude lands in a chosen region under realistic settings
  function automatic sample_t shaped_sample(input shape_e shape, input logic [STAMP_W-1:0] ms);
    sample_t s;
    int      lead;
    s.operation = OP_SAMPLE;
    s.now_ms    = ms;
    case (shape)
      SHAPE_REST: begin
        s.accel_x = jitter(0, 600);
        s.accel_y = jitter(0, 600);
        s.accel_z = jitter($urandom_range(1) ? 4096 : -4096, 300);
      end
      SHAPE_FREE: begin
        s.accel_x = jitter(0, 900);
        s.accel_y = jitter(0, 900);
        s.accel_z = jitter(0, 900);
      end
      SHAPE_HARD: begin
        lead = $urandom_range(32767, 11000);
        if ($urandom_range(1)) lead = -lead - 1;
        s.accel_x = ACCEL_W'($urandom);
        s.accel_y = ACCEL_W'($urandom);
        s.accel_z = ACCEL_W'($urandom);
        case ($urandom_range(2))
          0: s.accel_x = ACCEL_W'(lead);
          1: s.accel_y = ACCEL_W'(lead);
          default: s.accel_z = ACCEL_W'(lead);
        endcase
      end
      SHAPE_WALK: begin
        s.accel_x = jitter(0, 500);
        s.accel_y = jitter(0, 500);
        s.accel_z = $urandom_range(1) ? jitter(6000, 1000) : jitter(2200, 700);
      end
      default: begin
        s.accel_x = ACCEL_W'($urandom);
        s.accel_y = ACCEL_W'($urandom);
        s.accel_z = ACCEL_W'($urandom);
      end
    endcase
    return s;
  endfunction

  // offer one item, hold it until taken, then record what it should produce
  task automatic send_item(input sample_t s);
    while (throttle && $urandom_range(99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.operation <= s.operation;
    sample_ch.accel_x   <= s.accel_x;
    sample_ch.accel_y   <= s.accel_y;
    sample_ch.accel_z   <= s.accel_z;
    sample_ch.now_ms    <= s.now_ms;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    pending_reports.push_back(fall_and_distance_step(s));
    items_sent++;
    if (s.operation == OP_CLEAR) clears_sent++;
  endtask

  // stop offering items until every owed report has come back
  task automatic wait_for_drain();
    sample_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    // the block keeps only the low bits of the narrow registers
    case (idx)
      REG_FREE_FALL_THRESHOLD:   cur_cfg.free_fall_threshold   = val;
      REG_IMPACT_THRESHOLD:      cur_cfg.impact_threshold      = val;
      REG_MOTION_HIGH_THRESHOLD: cur_cfg.motion_high_threshold = val;
      REG_MOTION_LOW_THRESHOLD:  cur_cfg.motion_low_threshold  = val;
      REG_HIT_WINDOW_MS:         cur_cfg.hit_window_ms         = val[WINDOW_W-1:0];
      REG_FALL_TIMEOUT_MS:       cur_cfg.fall_timeout_ms       = val;
      REG_WALKING_SPEED_MM_S:    cur_cfg.walking_speed_mm_s    = val[SPEED_W-1:0];
      REG_SENSOR_ENABLED:        cur_cfg.sensor_enabled        = val[0];
      default: ;
    endcase
  endtask

  // write every register once the block has gone quiet
  task automatic program_all(input logic [CFG_DATA_W-1:0] ff, imp, mot_hi, mot_lo,
                             input logic [CFG_DATA_W-1:0] win, tmo, spd, en);
    wait_for_drain();
    // an accepted item passes through the input and then the result register
    repeat (2) @(posedge clk);
    write_reg(REG_FREE_FALL_THRESHOLD, ff);
    write_reg(REG_IMPACT_THRESHOLD, imp);
    write_reg(REG_MOTION_HIGH_THRESHOLD, mot_hi);
    write_reg(REG_MOTION_LOW_THRESHOLD, mot_lo);
    write_reg(REG_HIT_WINDOW_MS, win);
    write_reg(REG_FALL_TIMEOUT_MS, tmo);
    write_reg(REG_WALKING_SPEED_MM_S, spd);
    write_reg(REG_SENSOR_ENABLED, en);
    cfg_we <= 1'b0;
  endtask

  // realistic settings near the defaults, or wild thresholds, windows and timeouts
  task automatic program_random_settings(input bit wild);
    if (!wild) begin
      program_all($urandom_range(8000000, 500000), $urandom_range(300000000, 40000000),
                  $urandom_range(40000000, 16000000), $urandom_range(16000000, 2000000),
                  {16'($urandom), 16'($urandom_range(3000, 50))},
                  $urandom_range(60000, 200), $urandom, 32'h1);
    end else begin
      program_all($urandom_range(MAG_TOP), $urandom_range(MAG_TOP),
                  $urandom_range(MAG_TOP), $urandom_range(MAG_TOP),
                  {16'($urandom), 16'($urandom_range(20))},
                  $urandom_range(1) ? 32'hFFFF_FFFF : 32'($urandom_range(50)),
                  $urandom, {31'($urandom), 1'b1});
    end
  endtask

  // mostly well-formed fall and walking episodes, with clears and noise
  task automatic run_random_items(input int count);
    sample_t            s;
    int                 stop_at, pick, d;
    logic [STAMP_W-1:0] hit_ms;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // rest, free fall, impact inside or past the window, then rest
        repeat ($urandom_range(3, 1)) begin
          stamp_ms += $urandom_range(200, 20);
          send_item(shaped_sample(SHAPE_REST, stamp_ms));
        end
        repeat ($urandom_range(3, 1)) begin
          stamp_ms += $urandom_range(60, 5);
          send_item(shaped_sample(SHAPE_FREE, stamp_ms));
        end
        if (cur_cfg.hit_window_ms != 0 && $urandom_range(99) < 70)
          d = $urandom_range(int'(cur_cfg.hit_window_ms) - 1);
        else
          d = int'(cur_cfg.hit_window_ms) + int'($urandom_range(300));
        stamp_ms += d;
        hit_ms    = stamp_ms;
        send_item(shaped_sample(SHAPE_HARD, stamp_ms));
        repeat ($urandom_range(4, 1)) begin
          stamp_ms += $urandom_range(500, 50);
          send_item(shaped_sample(SHAPE_REST, stamp_ms));
        end
        // land on or just past the timeout edge
        if ($urandom_range(99) < 30) begin
          stamp_ms = hit_ms + cur_cfg.fall_timeout_ms + $urandom_range(1);
          send_item(shaped_sample(SHAPE_REST, stamp_ms));
        end
      end else if (pick < 55) begin
        repeat ($urandom_range(12, 3)) begin
          stamp_ms += $urandom_range(150, 5);
          send_item(shaped_sample($urandom_range(3) != 0 ? SHAPE_WALK : SHAPE_REST,
                                  stamp_ms));
        end
      end else if (pick < 63) begin
        s           = shaped_sample(SHAPE_ANY, $urandom);
        s.operation = OP_CLEAR;
        send_item(s);
      end else begin
        pick = $urandom_range(99);
        if (pick < 80)      stamp_ms += $urandom_range(1000);
        else if (pick < 95) stamp_ms  = $urandom;
        send_item(shaped_sample(SHAPE_ANY, stamp_ms));
      end
      if ($urandom_range(199) == 0) wait_for_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset settings: first sample, fall inside and at the window edge,
  // timeout edge, clear item and timestamp wrap
  task automatic test_default_settings();
    // first sample adds no distance, at rest inside the motion band
    send_item(make_item(OP_SAMPLE, 0, 0, 4096, 32'd100));
    send_item(make_item(OP_SAMPLE, 0, 0, 6000, 32'd200));
    // free fall then impact one ms inside the window
    send_item(make_item(OP_SAMPLE, 0, 0, 0, 32'd1000));
    send_item(make_item(OP_SAMPLE, 20000, 0, 0, 32'd1999));
    send_item(make_item(OP_SAMPLE, 0, 0, 4096, 32'd2100));
    // exactly the timeout keeps the latch, one more ms clears it
    send_item(make_item(OP_SAMPLE, 0, 0, 4096, 32'd31999));
    send_item(make_item(OP_SAMPLE, 0, 0, 4096, 32'd32000));
    // impact exactly at the window length is too late
    send_item(make_item(OP_SAMPLE, 0, 0, 0, 32'd40000));
    send_item(make_item(OP_SAMPLE, 32767, 32767, 32767, 32'd41000));
    // clear disarms, so the largest magnitude brings no fall
    send_item(make_clear());
    send_item(make_item(OP_SAMPLE, -32768, -32768, -32768, 32'd41500));
    send_item(make_item(OP_SAMPLE, 0, 0, 0, 32'd42000));
    send_item(make_item(OP_SAMPLE, -32768, 0, 0, 32'd42500));
    send_item(make_clear());
    // timestamp wrap
    send_item(make_item(OP_SAMPLE, 0, 0, 4096, 32'hFFFF_FF00));
    send_item(make_item(OP_SAMPLE, 0, 0, -6000, 32'h0000_0010));
  endtask

  // extreme register values, disabled sensor, misordered thresholds
  task automatic test_register_extremes();
    // always moving at top speed with the longest gaps: distance saturates
    program_all(32'd0, MAG_TOP, 32'd0, MAG_TOP, 32'hABCD_FFFF, 32'hFFFF_FFFF,
                32'h1234_FFFF, 32'hFFFF_FFFF);
    send_item(make_item(OP_SAMPLE, 100, -100, 0, 32'h0000_0000));
    send_item(make_item(OP_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF));
    send_item(make_item(OP_SAMPLE, 32767, 0, 0, 32'hFFFF_FFFE));
    send_item(make_item(OP_SAMPLE, 0, 32767, 0, 32'hFFFF_FFFD));
    // bit zero of the enable is low: samples leave everything alone
    program_all(RST_FREE_FALL_THRESHOLD, RST_IMPACT_THRESHOLD, RST_MOTION_HIGH_THRESHOLD,
                RST_MOTION_LOW_THRESHOLD, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFE);
    send_item(make_item(OP_SAMPLE, -32768, 12000, 5, 32'd5));
    send_item(make_clear());
    send_item(make_item(OP_SAMPLE, 0, 0, 0, 32'd6));
    // free-fall threshold above impact: one sample arms and hits,
    // a later one past the zero timeout clears it
    program_all(MAG_TOP, 32'd0, 32'd0, 32'd0, 32'hFFFF_0001, 32'd0, 32'd0, 32'h0000_0003);
    send_item(make_item(OP_SAMPLE, 0, 0, 4096, 32'd100));
    send_item(make_item(OP_SAMPLE, -32768, -32768, -32768, 32'd103));
    send_item(make_clear());
  endtask

  task automatic test_random_traffic();
    stamp_ms = $urandom;
    program_all(RST_FREE_FALL_THRESHOLD, RST_IMPACT_THRESHOLD, RST_MOTION_HIGH_THRESHOLD,
                RST_MOTION_LOW_THRESHOLD, CFG_DATA_W'(RST_HIT_WINDOW_MS),
                RST_FALL_TIMEOUT_MS, CFG_DATA_W'(RST_WALKING_SPEED_MM_S),
                CFG_DATA_W'(RST_SENSOR_ENABLED));
    run_random_items(PHASE_ITEMS);
    // back to back on both channels for a whole phase
    throttle = 1'b0;
    program_random_settings(1'b0);
    run_random_items(PHASE_ITEMS);
    throttle = 1'b1;
    program_random_settings(1'b0);
    run_random_items(PHASE_ITEMS);
    program_random_settings(1'b1);
    run_random_items(PHASE_ITEMS);
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // receiver stalls at random while throttled
  initial begin : result_ready_drive
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= throttle ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  // compare every taken report with the oldest one owed
  always @(posedge clk) begin : result_compare
    result_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.fall_flag    = result_ch.fall_flag;
      got.fall_event   = result_ch.fall_event;
      got.moving       = result_ch.moving;
      got.speed_mm_s   = result_ch.speed_mm_s;
      got.distance_um  = result_ch.distance_um;
      got.magnitude_sq = result_ch.magnitude_sq;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: report with nothing owed: mag=%0d dist=%0d", $realtime,
                   got.magnitude_sq, got.distance_um);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("%0t: mismatch exp det=%0b evt=%0b mov=%0b spd=%0d dist=%0d mag=%0d",
                     $realtime, want.fall_flag, want.fall_event, want.moving,
                     want.speed_mm_s, want.distance_um, want.magnitude_sq);
            $display("%0t: mismatch got det=%0b evt=%0b mov=%0b spd=%0d dist=%0d mag=%0d",
                     $realtime, got.fall_flag, got.fall_event, got.moving,
                     got.speed_mm_s, got.distance_um, got.magnitude_sq);
          end
        end
      end
    end
  end

  // ends the run if neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin : run
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.operation <= OP_SAMPLE;
    sample_ch.accel_x   <= '0;
    sample_ch.accel_y   <= '0;
    sample_ch.accel_z   <= '0;
    sample_ch.now_ms    <= '0;
    stamp_ms             = '0;

    // predictor matches the block straight after reset
    cur_cfg.free_fall_threshold   = RST_FREE_FALL_THRESHOLD;
    cur_cfg.impact_threshold      = RST_IMPACT_THRESHOLD;
    cur_cfg.motion_high_threshold = RST_MOTION_HIGH_THRESHOLD;
    cur_cfg.motion_low_threshold  = RST_MOTION_LOW_THRESHOLD;
    cur_cfg.hit_window_ms         = RST_HIT_WINDOW_MS;
    cur_cfg.fall_timeout_ms       = RST_FALL_TIMEOUT_MS;
    cur_cfg.walking_speed_mm_s    = RST_WALKING_SPEED_MM_S;
    cur_cfg.sensor_enabled        = RST_SENSOR_ENABLED;
    drop_fall();
    seen_sample = 1'b0;
    prev_stamp  = '0;
    dist_acc    = '0;
    moving_now  = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_register_extremes();
    test_random_traffic();

    // everything owed has come back; then wait for strays
    wait_for_drain();
    repeat (4) @(posedge clk);

    $display("covered %0d items (%0d clears), %0d reports checked",
             items_sent, clears_sent, reports_checked);
    $display("covered %0d fall events, %0d timeout clears, %0d distance saturations",
             falls_seen, timeouts_seen, sat_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatching reports", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
